// ===== rtl/core/itr_pkg.sv =====
// Package for the interval timer and interrupt register block.
// Holds operation codes, register indexes, bit masks and the result type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itr_pkg;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_EXPIRE = 2'd2;

    localparam logic [3:0] REG_PORT_A   = 4'h0;
    localparam logic [3:0] REG_LATCH_LO = 4'h4;
    localparam logic [3:0] REG_LATCH_HI = 4'h5;
    localparam logic [3:0] REG_ICR      = 4'hD;
    localparam logic [3:0] REG_CTRL_A   = 4'hE;
    localparam logic [3:0] REG_CTRL_B   = 4'hF;

    localparam logic [7:0] CTRL_KEEP     = 8'hEF;
    localparam int         CTRL_START    = 0;
    localparam int         CTRL_ONESHOT  = 3;
    localparam int         CTRL_FORCE    = 4;
    localparam int         ICR_SET       = 7;
    localparam int         MASK_TIMER_A  = 0;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        timer_restart;
        logic [15:0] restart_count;
        logic        nmi_pulse;
        logic        bank_changed;
        logic        irq_pending;
    } itr_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/interval_timer_interrupt_regs_top.sv =====
// Each result beat is registered in the head or, on a stall, the skid register.
// Throughput: one beat per cycle from the single-pass step logic of itr_regfile;
// the two-entry output stage keeps input open until the skid entry is full.
// Reset: rst_n is asynchronous and active low; it clears the register shadow,
// timer latch, interrupt mask and flags, control registers and output stage.
// Depends on itr_pkg and itr_regfile.
`timescale 1ns / 1ps
`default_nettype none

module interval_timer_interrupt_regs_top
    import itr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  op,
    input  wire logic [3:0]  reg_index,
    input  wire logic [7:0]  write_data,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [7:0]  read_data,
    output      logic        timer_restart,
    output      logic [15:0] restart_count,
    output      logic        nmi_pulse,
    output      logic        bank_changed,
    output      logic        irq_pending
);

    itr_result_t step_result;
    itr_result_t out_data_reg, out_data_next;
    itr_result_t skid_data_reg, skid_data_next;
    logic        out_valid_reg, out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    logic        in_fire;
    logic        out_fire;

    // Take a new beat whenever the skid entry is free; the state update
    // happens on the accepting edge so the next beat sees it at once.
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    itr_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_fire),
        .op         (op),
        .reg_index  (reg_index),
        .write_data (write_data),
        .result     (step_result)
    );

    // Output stage: the head register feeds the port; the skid register
    // catches a beat that arrives while the head is stalled.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                // drain the skid entry into the head
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                if (in_fire)
                    out_data_next = step_result;
            end
        end
        else if (in_fire)
        begin
            // head stalled: hold the new beat aside
            skid_valid_next = 1'b1;
            skid_data_next  = step_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset; it only matters under its valid bit.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = out_data_reg.read_data;
    assign timer_restart = out_data_reg.timer_restart;
    assign restart_count = out_data_reg.restart_count;
    assign nmi_pulse     = out_data_reg.nmi_pulse;
    assign bank_changed  = out_data_reg.bank_changed;
    assign irq_pending   = out_data_reg.irq_pending;

`ifndef SYNTHESIS
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a beat while the head is empty");
    a_nmi_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.nmi_pulse |-> out_data_reg.irq_pending)
        else $error("interrupt pulse without pending flag");
    a_count_only_on_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.timer_restart |-> out_data_reg.restart_count == 16'h0000)
        else $error("restart count driven without a restart");
    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && in_fire |=> skid_valid_reg)
        else $error("beat accepted under a stall was not held");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/itr_regfile.sv =====
// Register state and single-pass step logic of the timer/interrupt block.
// Depends on itr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itr_regfile
    import itr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire logic [1:0]  op,
    input  wire logic [3:0]  reg_index,
    input  wire logic [7:0]  write_data,
    output itr_result_t      result
);

    logic [7:0]  shadow_reg [16];
    logic [15:0] latch_reg, latch_next;
    logic [4:0]  mask_reg, mask_next;
    logic        flag_ta_reg, flag_ta_next;
    logic        flag_irq_reg, flag_irq_next;
    logic [7:0]  ctrl_a_reg, ctrl_a_next;
    logic [7:0]  ctrl_b_reg, ctrl_b_next;
    logic        shadow_wr;
    logic [7:0]  shadow_wdata;
    logic [7:0]  rd;
    logic        restart;
    logic        nmi;
    logic        bank;

    always_comb
    begin
        latch_next    = latch_reg;
        mask_next     = mask_reg;
        flag_ta_next  = flag_ta_reg;
        flag_irq_next = flag_irq_reg;
        ctrl_a_next   = ctrl_a_reg;
        ctrl_b_next   = ctrl_b_reg;
        shadow_wr     = 1'b0;
        shadow_wdata  = write_data;
        rd            = 8'h00;
        restart       = 1'b0;
        nmi           = 1'b0;
        bank          = 1'b0;
        case (op)
            OP_WRITE:
            begin
                shadow_wr = 1'b1;
                case (reg_index)
                    REG_PORT_A:   bank = 1'b1;
                    REG_LATCH_LO: latch_next[7:0] = write_data;
                    REG_LATCH_HI:
                    begin
                        latch_next[15:8] = write_data;
                        restart          = ctrl_a_reg[CTRL_START];
                    end
                    REG_ICR:
                    begin
                        if (write_data[ICR_SET])
                            mask_next = mask_reg | write_data[4:0];
                        else
                            mask_next = mask_reg & ~write_data[4:0];
                    end
                    REG_CTRL_A:
                    begin
                        ctrl_a_next = write_data & CTRL_KEEP;
                        restart     = write_data[CTRL_FORCE] & write_data[CTRL_START];
                    end
                    REG_CTRL_B:   ctrl_b_next = write_data & CTRL_KEEP;
                    default:      ;
                endcase
            end
            OP_READ:
            begin
                shadow_wr = 1'b1;
                case (reg_index)
                    REG_LATCH_LO: rd = latch_reg[7:0];
                    REG_LATCH_HI: rd = latch_reg[15:8];
                    REG_ICR:
                    begin
                        rd            = {flag_irq_reg, 6'b000000, flag_ta_reg};
                        flag_ta_next  = 1'b0;
                        flag_irq_next = 1'b0;
                    end
                    REG_CTRL_A:   rd = ctrl_a_reg;
                    REG_CTRL_B:   rd = ctrl_b_reg;
                    default:      rd = shadow_reg[reg_index];
                endcase
                shadow_wdata = rd;
            end
            OP_EXPIRE:
            begin
                if (ctrl_a_reg[CTRL_START])
                begin
                    // one-shot stops, continuous reloads and runs on
                    if (ctrl_a_reg[CTRL_ONESHOT])
                        ctrl_a_next[CTRL_START] = 1'b0;
                    else
                        restart = 1'b1;
                    flag_ta_next = 1'b1;
                    if (mask_reg[MASK_TIMER_A] && !flag_irq_reg)
                    begin
                        flag_irq_next = 1'b1;
                        nmi           = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        result.read_data     = rd;
        result.timer_restart = restart;
        result.restart_count = restart ? latch_next : 16'h0000;
        result.nmi_pulse     = nmi;
        result.bank_changed  = bank;
        result.irq_pending   = flag_irq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                shadow_reg[i] <= 8'h00;
            latch_reg    <= 16'h0000;
            mask_reg     <= 5'h00;
            flag_ta_reg  <= 1'b0;
            flag_irq_reg <= 1'b0;
            ctrl_a_reg   <= 8'h00;
            ctrl_b_reg   <= 8'h00;
        end
        else if (step_en)
        begin
            if (shadow_wr)
                shadow_reg[reg_index] <= shadow_wdata;
            latch_reg    <= latch_next;
            mask_reg     <= mask_next;
            flag_ta_reg  <= flag_ta_next;
            flag_irq_reg <= flag_irq_next;
            ctrl_a_reg   <= ctrl_a_next;
            ctrl_b_reg   <= ctrl_b_next;
        end
    end

`ifndef SYNTHESIS
    a_ctrl_force_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_a_reg[CTRL_FORCE] && !ctrl_b_reg[CTRL_FORCE])
        else $error("force-load bit stored in a control register");
    a_nmi_needs_mask: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.nmi_pulse |-> mask_reg[MASK_TIMER_A] && !flag_irq_reg)
        else $error("interrupt signalled while masked or already pending");
    a_irq_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        flag_irq_reg |-> flag_ta_reg)
        else $error("interrupt flag set without timer A flag");
`endif

endmodule

`default_nettype wire
